// ===== design/r10rm_pkg.sv =====
// r10rm_pkg: shared types and constants for the raid10 near-2 read mapper
// no dependencies; used by r10rm_ctrl, r10rm_dp and the top level
package r10rm_pkg;

    localparam int DEF_MAX_MEMBERS  = 16;
    localparam int DEF_MAX_SEGMENTS = 64;

    localparam int SECTOR_SHIFT = 9;
    localparam int ADDR_W       = 48;
    localparam int SECT_ADDR_W  = ADDR_W - SECTOR_SHIFT;
    localparam int LEN_W        = 15;
    localparam int CS_W         = 16;
    localparam int CHUNK_W      = CS_W + SECTOR_SHIFT;
    localparam int MC_W         = 5;
    localparam int MASK_W       = 16;
    localparam int MEMBER_W     = 4;
    localparam int GRP_W        = 3;
    localparam int CNT_W        = 6;

    localparam logic [LEN_W-1:0] MAX_REQUEST = 15'd32256;

    // configuration register indexes
    localparam logic [1:0] REG_CHUNK_SECTORS = 2'd0;
    localparam logic [1:0] REG_MEMBER_COUNT  = 2'd1;
    localparam logic [1:0] REG_PRESENT_MASK  = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_GEOM  = 2'd1;
    localparam logic [1:0] ST_NO_MIRROR = 2'd2;

    typedef struct packed {
        logic [ADDR_W-1:0] logical_offset;
        logic [LEN_W-1:0]  request_length;
    } t_in_item;

    typedef struct packed {
        logic [1:0]          status;
        logic [MEMBER_W-1:0] member_index;
        logic [ADDR_W-1:0]   member_offset;
        logic [LEN_W-1:0]    segment_length;
        logic [LEN_W-1:0]    buffer_offset;
        logic                last;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic       start;
        logic       div_step;
        logic       div_grp;
        logic       div2_load;
        logic       mul_load;
        logic       mul_step;
        logic [3:0] mul_bit;
        logic       emit;
        logic       emit_special;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic geom_bad;
        logic len_zero;
        logic out_free;
        logic emit_last;
    } t_stat;

endpackage

// ===== design/r10rm_ctrl.sv =====
// r10rm_ctrl: sequencer for division, multiply and segment emission
// depends on r10rm_pkg
module r10rm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  r10rm_pkg::t_stat  i_stat,
    output r10rm_pkg::t_cmd   o_cmd
);
    import r10rm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_SPECIAL, S_DIV1, S_LOAD2, S_DIV2, S_MLOAD, S_MUL, S_SEG
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    assign o_in_stall = (r_state != S_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.mul_bit = r_cnt[3:0];
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.geom_bad || i_stat.len_zero) begin
                    n_state = S_SPECIAL;
                end else begin
                    n_state = S_DIV1;
                    n_cnt = CNT_W'(SECT_ADDR_W - 1);
                end
            end
            S_SPECIAL: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_special = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_DIV1: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) n_state = S_LOAD2;
            end
            S_LOAD2: begin
                o_cmd.div2_load = 1'b1;
                n_state = S_DIV2;
                n_cnt = CNT_W'(SECT_ADDR_W - 1);
            end
            S_DIV2: begin
                o_cmd.div_step = 1'b1;
                o_cmd.div_grp  = 1'b1;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) n_state = S_MLOAD;
            end
            S_MLOAD: begin
                o_cmd.mul_load = 1'b1;
                n_state = S_MUL;
                n_cnt = CNT_W'(CS_W - 1);
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) n_state = S_SEG;
            end
            S_SEG: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.emit_last) n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// ===== design/r10rm_dp.sv =====
// r10rm_dp: config registers, shared divider, shift-add multiplier, segment logic
// depends on r10rm_pkg
module r10rm_dp #(
    parameter int MAX_MEMBERS  = r10rm_pkg::DEF_MAX_MEMBERS,
    parameter int MAX_SEGMENTS = r10rm_pkg::DEF_MAX_SEGMENTS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [1:0]           i_cfg_index,
    input  logic [15:0]          i_cfg_data,
    input  r10rm_pkg::t_in_item  i_in_data,
    output r10rm_pkg::t_out_item o_out_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    input  r10rm_pkg::t_cmd      i_cmd,
    output r10rm_pkg::t_stat     o_stat
);
    import r10rm_pkg::*;

    localparam int SEG_W = $clog2(MAX_SEGMENTS + 1);

    logic [CS_W-1:0]        r_cs;
    logic [MC_W-1:0]        r_mc;
    logic [MASK_W-1:0]      r_mask;
    logic [SECTOR_SHIFT-1:0] r_lo_low;
    logic [LEN_W-1:0]       r_len;
    logic [LEN_W-1:0]       r_done;
    logic [SECT_ADDR_W-1:0] r_quo;
    logic [CS_W-1:0]        r_rem;
    logic [SECT_ADDR_W-1:0] r_row;
    logic [SECT_ADDR_W-1:0] r_acc;
    logic [CHUNK_W-1:0]     r_intra;
    logic [GRP_W-1:0]       r_g;
    logic [SEG_W-1:0]       r_seg;
    t_out_item              r_out;
    logic                   r_out_valid;

    logic [3:0]        groups;
    logic [CS_W-1:0]   divisor;
    logic [CS_W:0]     trial;
    logic              ge;
    logic [CHUNK_W-1:0] chunk, left;
    logic [LEN_W-1:0]  remain, take, done_n;
    logic [MEMBER_W-1:0] even, odd;
    logic              pair_ok, last_n;
    logic [ADDR_W-1:0] moff;
    logic [LEN_W-1:0]  sat_len;

    // configuration write, ready always high
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cs   <= CS_W'(128);
            r_mc   <= MC_W'(2);
            r_mask <= '1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_CHUNK_SECTORS: r_cs   <= i_cfg_data;
                REG_MEMBER_COUNT:  r_mc   <= i_cfg_data[MC_W-1:0];
                REG_PRESENT_MASK:  r_mask <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign groups = r_mc[4:1];

    // geometry and length checks
    assign o_stat.geom_bad = (r_mc < MC_W'(2)) || r_mc[0] || (32'(r_mc) > MAX_MEMBERS)
                           || (r_mc > MC_W'(16)) || (r_cs == '0);
    assign o_stat.len_zero = (r_len == '0);
    assign o_stat.out_free = !r_out_valid || !i_out_stall;

    // restoring divider step, shared by both divisions
    assign divisor = i_cmd.div_grp ? CS_W'(groups) : r_cs;
    assign trial   = {r_rem, r_quo[SECT_ADDR_W-1]};
    assign ge      = (trial >= {1'b0, divisor});

    // segment arithmetic
    assign chunk   = {r_cs, {SECTOR_SHIFT{1'b0}}};
    assign left    = chunk - r_intra;
    assign remain  = r_len - r_done;
    assign take    = (CHUNK_W'(remain) < left) ? remain : left[LEN_W-1:0];
    assign done_n  = r_done + take;
    assign even    = {r_g, 1'b0};
    assign odd     = even + 1'b1;
    assign pair_ok = r_mask[even] || r_mask[odd];
    assign last_n  = (done_n >= r_len) || (32'(r_seg) + 1 >= MAX_SEGMENTS);
    assign moff    = {r_acc, {SECTOR_SHIFT{1'b0}}} + ADDR_W'(r_intra);
    assign o_stat.emit_last = !pair_ok || last_n;

    assign sat_len = (i_in_data.request_length > MAX_REQUEST) ? MAX_REQUEST
                                                              : i_in_data.request_length;

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_quo    <= i_in_data.logical_offset[ADDR_W-1:SECTOR_SHIFT];
            r_lo_low <= i_in_data.logical_offset[SECTOR_SHIFT-1:0];
            r_len    <= sat_len;
            r_rem    <= '0;
            r_done   <= '0;
            r_seg    <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= ge ? CS_W'(trial - {1'b0, divisor}) : trial[CS_W-1:0];
            r_quo <= {r_quo[SECT_ADDR_W-2:0], ge};
        end
        if (i_cmd.div2_load) begin
            r_intra <= {r_rem, r_lo_low};
            r_rem   <= '0;
        end
        if (i_cmd.mul_load) begin
            r_row <= r_quo;
            r_g   <= r_rem[GRP_W-1:0];
            r_acc <= '0;
        end
        if (i_cmd.mul_step) begin
            r_acc <= {r_acc[SECT_ADDR_W-2:0], 1'b0}
                   + (r_cs[i_cmd.mul_bit] ? r_row : '0);
        end
        if (i_cmd.emit) begin
            r_done  <= done_n;
            r_seg   <= r_seg + 1'b1;
            r_intra <= '0;
            if ({1'b0, r_g} == groups - 4'd1) begin
                r_g   <= '0;
                r_acc <= r_acc + SECT_ADDR_W'(r_cs);
            end else begin
                r_g <= r_g + 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit || i_cmd.emit_special) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_special) begin
            r_out <= {(o_stat.geom_bad ? ST_BAD_GEOM : ST_OK), MEMBER_W'(0), ADDR_W'(0),
                      LEN_W'(0), LEN_W'(0), 1'b1};
        end else if (i_cmd.emit) begin
            r_out.member_offset <= moff;
            r_out.buffer_offset <= r_done;
            if (pair_ok) begin
                r_out.status         <= ST_OK;
                r_out.member_index   <= r_mask[even] ? even : odd;
                r_out.segment_length <= take;
                r_out.last           <= last_n;
            end else begin
                r_out.status         <= ST_NO_MIRROR;
                r_out.member_index   <= even;
                r_out.segment_length <= '0;
                r_out.last           <= 1'b1;
            end
        end
    end

    assign o_out_data  = r_out;
    assign o_out_valid = r_out_valid;

endmodule

// ===== design/raid10_near2_read_mapper_top.sv =====
// Splits a read request into chunk-bounded segments of a RAID10 near-2 layout.
// An item with valid geometry and nonzero length runs a 39-step restoring
// divide by chunk size, a 39-step divide by pair count on the same shared
// divider unit, a 16-step shift-add multiply for the row base, then one
// segment per cycle while the output is not stalled. One item is in work at
// a time; the input stalls from acceptance until its last result is loaded.
// raid10_near2_read_mapper_top: top level; depends on r10rm_pkg, r10rm_ctrl, r10rm_dp
module raid10_near2_read_mapper_top #(
    parameter int MAX_MEMBERS  = r10rm_pkg::DEF_MAX_MEMBERS,
    parameter int MAX_SEGMENTS = r10rm_pkg::DEF_MAX_SEGMENTS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [15:0]          i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  r10rm_pkg::t_in_item  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output r10rm_pkg::t_out_item o_out_data
);
    import r10rm_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    // controller
    r10rm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // datapath
    r10rm_dp #(
        .MAX_MEMBERS  (MAX_MEMBERS),
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .o_out_data  (o_out_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_cmd       (cmd),
        .o_stat      (stat)
    );

endmodule
